FILE: rtl/core/usbmidi_pkg.sv
`timescale 1ns / 1ps

package usbmidi_pkg;

  localparam int DEFAULT_STORE_DEPTH = 1024;
  // store is split by position modulo four so one packet writes up to three banks at once
  localparam int NUM_BANKS = 4;

  localparam logic [7:0] SYSEX_START = 8'hF0;

  localparam logic OP_PACKET = 1'b0;
  localparam logic OP_READ   = 1'b1;

  localparam logic [7:0] HDR_NOP           = 8'h00;
  localparam logic [7:0] HDR_SYSEX_CONT    = 8'h04;
  localparam logic [7:0] HDR_SYSEX_END1    = 8'h05;
  localparam logic [7:0] HDR_SYSEX_END2    = 8'h06;
  localparam logic [7:0] HDR_SYSEX_END3    = 8'h07;
  localparam logic [7:0] HDR_NOTE_OFF      = 8'h08;
  localparam logic [7:0] HDR_NOTE_ON       = 8'h09;
  localparam logic [7:0] HDR_POLY_KEY      = 8'h0A;
  localparam logic [7:0] HDR_CTRL_CHANGE   = 8'h0B;
  localparam logic [7:0] HDR_PROG_CHANGE   = 8'h0C;
  localparam logic [7:0] HDR_CHAN_PRESSURE = 8'h0D;
  localparam logic [7:0] HDR_PITCH_BEND    = 8'h0E;

  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_CHAN  = 2'd1;
  localparam logic [1:0] KIND_SYSEX = 2'd2;
  localparam logic [1:0] KIND_READ  = 2'd3;

  localparam logic [15:0] SINGLE_ID_MARK = 16'h8000;

  typedef struct packed {
    logic       operation;
    logic [7:0] header;
    logic [7:0] byte_one;
    logic [7:0] byte_two;
    logic [7:0] byte_three;
    logic [9:0] read_index;
  } pkt_t;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [7:0]  status;
    logic [7:0]  data_first;
    logic [7:0]  data_second;
    logic [9:0]  sysex_length;
    logic [15:0] manufacturer_id;
    logic        overflow;
    logic [7:0]  read_byte;
  } result_t;

  // copies of store positions 1 to 3 for the manufacturer id
  typedef struct packed {
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
  } id_bytes_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] bank;
  } rd_ctl_t;

endpackage

FILE: rtl/core/usbmidi_if.sv
`timescale 1ns / 1ps

interface usbmidi_pkt_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] header;
  logic [7:0] byte_one;
  logic [7:0] byte_two;
  logic [7:0] byte_three;
  logic [9:0] read_index;

  modport source (
    output valid, operation, header, byte_one, byte_two, byte_three, read_index,
    input  ready
  );
  modport sink (
    input  valid, operation, header, byte_one, byte_two, byte_three, read_index,
    output ready
  );
endinterface

interface usbmidi_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_kind;
  logic [7:0]  status;
  logic [7:0]  data_first;
  logic [7:0]  data_second;
  logic [9:0]  sysex_length;
  logic [15:0] manufacturer_id;
  logic        overflow;
  logic [7:0]  read_byte;

  modport source (
    output valid, event_kind, status, data_first, data_second, sysex_length,
    output manufacturer_id, overflow, read_byte,
    input  ready
  );
  modport sink (
    input  valid, event_kind, status, data_first, data_second, sysex_length,
    input  manufacturer_id, overflow, read_byte,
    output ready
  );
endinterface

FILE: rtl/core/usbmidi_ram.sv
`timescale 1ns / 1ps

module usbmidi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/usbmidi_decode.sv
`timescale 1ns / 1ps

module usbmidi_decode #(
  parameter int STORE_DEPTH = usbmidi_pkg::DEFAULT_STORE_DEPTH,
  localparam int FILL_W = $clog2(STORE_DEPTH + 1),
  localparam int ROWS = (STORE_DEPTH + usbmidi_pkg::NUM_BANKS - 1) / usbmidi_pkg::NUM_BANKS,
  localparam int ROW_W = $clog2(ROWS)
) (
  input  usbmidi_pkg::pkt_t      pkt,
  input  logic [FILL_W-1:0]      fill,
  input  usbmidi_pkg::id_bytes_t ids,
  output logic [FILL_W-1:0]      fill_next,
  output usbmidi_pkg::id_bytes_t ids_next,
  output usbmidi_pkg::result_t   res,
  output usbmidi_pkg::rd_ctl_t   rd,
  output logic [ROW_W-1:0]       rd_row,
  output logic [usbmidi_pkg::NUM_BANKS-1:0] wr_en,
  output logic [ROW_W-1:0]       wr_row [usbmidi_pkg::NUM_BANKS],
  output logic [7:0]             wr_data [usbmidi_pkg::NUM_BANKS]
);
  import usbmidi_pkg::*;

  localparam int IDX_W = (FILL_W > 10) ? FILL_W : 10;

  logic [1:0]        n;
  logic [FILL_W-1:0] base;
  logic [FILL_W:0]   sum;
  logic [FILL_W:0]   len_full;
  logic              fits;
  logic [FILL_W:0]   pos [3];
  logic [7:0]        bytes [3];
  logic [IDX_W-1:0]  idx_x;
  logic [IDX_W-1:0]  fill_x;

  // header 4 carries three bytes, headers 5 to 7 carry header minus four
  assign n = (pkt.header == HDR_SYSEX_CONT) ? 2'd3 : pkt.header[1:0];
  assign base = (pkt.byte_one == SYSEX_START) ? '0 : fill;
  assign sum = {1'b0, base} + (FILL_W + 1)'(n);
  assign fits = sum <= (FILL_W + 1)'(STORE_DEPTH);
  assign len_full = sum - (FILL_W + 1)'(2);

  assign bytes[0] = pkt.byte_one;
  assign bytes[1] = pkt.byte_two;
  assign bytes[2] = pkt.byte_three;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pos[i] = {1'b0, base} + (FILL_W + 1)'(i);
    end
  end

  assign idx_x = IDX_W'(pkt.read_index);
  assign fill_x = IDX_W'(fill);
  assign rd_row = idx_x[ROW_W+1:2];

  always_comb begin
    fill_next = fill;
    ids_next = ids;
    res = '0;
    rd.hit = 1'b0;
    rd.bank = pkt.read_index[1:0];
    wr_en = '0;
    for (int b = 0; b < NUM_BANKS; b++) begin
      wr_row[b] = '0;
      wr_data[b] = '0;
    end

    if (pkt.operation == OP_READ) begin
      res.event_kind = KIND_READ;
      rd.hit = idx_x < fill_x;
    end else begin
      unique case (pkt.header) inside
        HDR_NOP: begin
        end
        HDR_NOTE_OFF, HDR_NOTE_ON, HDR_POLY_KEY, HDR_CTRL_CHANGE, HDR_PITCH_BEND: begin
          fill_next = '0;
          res.event_kind = KIND_CHAN;
          res.status = pkt.byte_one;
          res.data_first = pkt.byte_two;
          res.data_second = pkt.byte_three;
        end
        HDR_PROG_CHANGE, HDR_CHAN_PRESSURE: begin
          fill_next = '0;
          res.event_kind = KIND_CHAN;
          res.status = pkt.byte_one;
          res.data_first = pkt.byte_two;
        end
        [HDR_SYSEX_CONT:HDR_SYSEX_END3]: begin
          fill_next = fits ? sum[FILL_W-1:0] : base;
          if (fits) begin
            for (int i = 0; i < 3; i++) begin
              if (2'(i) < n) begin
                wr_en[pos[i][1:0]] = 1'b1;
                wr_row[pos[i][1:0]] = pos[i][ROW_W+1:2];
                wr_data[pos[i][1:0]] = bytes[i];
                if (pos[i] == (FILL_W + 1)'(1)) ids_next.b1 = bytes[i];
                if (pos[i] == (FILL_W + 1)'(2)) ids_next.b2 = bytes[i];
                if (pos[i] == (FILL_W + 1)'(3)) ids_next.b3 = bytes[i];
              end
            end
          end
          if (pkt.header != HDR_SYSEX_CONT) begin
            res.event_kind = KIND_SYSEX;
            if (!fits) begin
              res.overflow = 1'b1;
            end else begin
              if (sum > (FILL_W + 1)'(2)) res.sysex_length = 10'(len_full);
              if (sum > (FILL_W + 1)'(1)) begin
                if (ids_next.b1 != 8'h00) begin
                  res.manufacturer_id = SINGLE_ID_MARK | {8'h00, ids_next.b1};
                end else if (sum > (FILL_W + 1)'(3)) begin
                  res.manufacturer_id = {1'b0, ids_next.b2, 7'b0} | {8'h00, ids_next.b3};
                end
              end
            end
          end
        end
        default: begin
          fill_next = '0;
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/usb_midi_packet_parser.sv
`timescale 1ns / 1ps

// channel  dir  handshake      payload
// packet   in   valid/ready    operation, header, byte_one..byte_three, read_index
// result   out  valid/ready    event_kind, status, data_first, data_second,
//                              sysex_length, manufacturer_id, overflow, read_byte
//
// one item per cycle while the result is not stalled; an accepted item reaches the result
// through the store read stage, then the output register
// the store is four single-port-write banks, so a packet writes all its bytes together when accepted
// reset clears the fill count and the pipeline; store contents are left as they are
// a stalled result holds the read stage; packet is ready while that stage is empty or advancing

module usb_midi_packet_parser #(
  parameter int STORE_DEPTH = usbmidi_pkg::DEFAULT_STORE_DEPTH
) (
  input logic         clk,
  input logic         rst,
  usbmidi_pkt_if.sink   packet,
  usbmidi_res_if.source result
);
  import usbmidi_pkg::*;

  localparam int FILL_W = $clog2(STORE_DEPTH + 1);
  localparam int ROWS = (STORE_DEPTH + NUM_BANKS - 1) / NUM_BANKS;
  localparam int ROW_W = $clog2(ROWS);

  pkt_t              pkt;
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_next;
  id_bytes_t         ids;
  id_bytes_t         ids_next;
  result_t           dec_res;
  rd_ctl_t           dec_rd;
  logic [ROW_W-1:0]  rd_row;
  logic [NUM_BANKS-1:0] wr_en;
  logic [ROW_W-1:0]  wr_row [NUM_BANKS];
  logic [7:0]        wr_data [NUM_BANKS];
  logic [7:0]        bank_dout [NUM_BANKS];

  logic    pkt_accept;
  logic    rd_en;
  logic    s1_valid;
  logic    s1_advance;
  result_t s1_res;
  rd_ctl_t s1_rd;
  result_t s1_out;
  logic    out_valid;
  result_t out_res;

  assign pkt = '{operation: packet.operation, header: packet.header,
                 byte_one: packet.byte_one, byte_two: packet.byte_two,
                 byte_three: packet.byte_three, read_index: packet.read_index};

  assign s1_advance = !out_valid || result.ready;
  assign packet.ready = !s1_valid || s1_advance;
  assign pkt_accept = packet.valid && packet.ready;
  assign rd_en = pkt_accept && (packet.operation == OP_READ);

  usbmidi_decode #(.STORE_DEPTH(STORE_DEPTH)) u_decode (
    .pkt       (pkt),
    .fill      (fill),
    .ids       (ids),
    .fill_next (fill_next),
    .ids_next  (ids_next),
    .res       (dec_res),
    .rd        (dec_rd),
    .rd_row    (rd_row),
    .wr_en     (wr_en),
    .wr_row    (wr_row),
    .wr_data   (wr_data)
  );

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    usbmidi_ram #(.WIDTH(8), .DEPTH(ROWS)) u_ram (
      .clk   (clk),
      .we    (pkt_accept && wr_en[b]),
      .waddr (wr_row[b]),
      .wdata (wr_data[b]),
      .re    (rd_en),
      .raddr (rd_row),
      .rdata (bank_dout[b])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (pkt_accept) begin
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pkt_accept) begin
      ids <= ids_next;
    end
  end

  // read stage: bank data arrives here in the cycle after the address
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (packet.ready) begin
      s1_valid <= pkt_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (pkt_accept) begin
      s1_res <= dec_res;
      s1_rd <= dec_rd;
    end
  end

  always_comb begin
    s1_out = s1_res;
    s1_out.read_byte = s1_rd.hit ? bank_dout[s1_rd.bank] : 8'h00;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_valid) begin
      out_res <= s1_out;
    end
  end

  assign result.valid = out_valid;
  assign result.event_kind = out_res.event_kind;
  assign result.status = out_res.status;
  assign result.data_first = out_res.data_first;
  assign result.data_second = out_res.data_second;
  assign result.sysex_length = out_res.sysex_length;
  assign result.manufacturer_id = out_res.manufacturer_id;
  assign result.overflow = out_res.overflow;
  assign result.read_byte = out_res.read_byte;

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(STORE_DEPTH))
    else $error("fill count past store depth");

  a_reset_fill: assert property (@(posedge clk)
    rst |=> fill == '0)
    else $error("fill count not cleared by reset");

  a_read_tracked: assert property (@(posedge clk) disable iff (rst)
    rd_en |=> s1_valid && (s1_res.event_kind == KIND_READ))
    else $error("read item lost before bank data returned");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_advance |=> s1_valid && $stable(s1_res) && $stable(s1_rd))
    else $error("read stage changed while output stalled");
`endif

endmodule
